FILE: sv/wrws_pkg.sv
// Package for the weighted random walk stepper: sizes and operation codes.
// Depends on nothing; used by the top level.
package wrws_pkg;
   localparam int MAX_NODES_DEF   = 1024;
   localparam int MAX_EDGES_DEF   = 4096;
   localparam int MAX_COLORS_DEF  = 16;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam logic [2:0] OP_WRITE_OFFSET = 3'd0;
   localparam logic [2:0] OP_WRITE_EDGE   = 3'd1;
   localparam logic [2:0] OP_WRITE_COLOR  = 3'd2;
   localparam logic [2:0] OP_START        = 3'd3;
   localparam logic [2:0] OP_STEP         = 3'd4;
endpackage

FILE: sv/wrws_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module wrws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: sv/weighted_random_walk_stepper.sv
// Top level of the weighted random walk stepper: sequencer and table memories.
// Depends on wrws_pkg and wrws_ram.
//
// Usage: each word on the req_ channel is one operation (table write, walk start
// or step) and yields exactly one word on the rsp_ channel with the walker state.
// Table writes, starts, unknown codes and steps on a finished walk go from
// acceptance to the done state, which raises rsp_valid and returns req_ready
// together. A step reads the two offsets of the current node, binary-searches
// the node's edge weights with one weight read and one compare per iteration
// (ceil(log2(degree)) iterations, twelve for a node that owns the whole table),
// then reads the chosen edge target and the target's color; a node without
// edges skips the search and the target read. Each memory has a single read
// port, so these reads follow one another. One word is in flight at a time.
// The response sits in an output register; the next request is accepted while
// it waits, but its result is held back until the previous response is taken.
// Reset clears the walker state (idle walk, done) and sets colors_present to
// one; the tables hold whatever they held and must be loaded before they are
// read. A stalled receiver simply holds rsp_valid and the word.
module weighted_random_walk_stepper
   import wrws_pkg::*;
#(
   parameter int MAX_NODES   = MAX_NODES_DEF,
   parameter int MAX_EDGES   = MAX_EDGES_DEF,
   parameter int MAX_COLORS  = MAX_COLORS_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [11:0] req_table_index,
   input  logic [12:0] req_entry_value,
   input  logic [15:0] req_edge_weight,
   input  logic [15:0] req_random_fraction,
   input  logic        csr_write_enable,
   input  logic [4:0]  csr_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_next_node,
   output logic [31:0] rsp_step_count,
   output logic        rsp_color_found,
   output logic [3:0]  rsp_found_color,
   output logic        rsp_walk_done
);
   localparam int NB = $clog2(MAX_NODES);
   localparam int OB = $clog2(MAX_NODES + 1);
   localparam int EB = $clog2(MAX_EDGES);
   localparam int CB = $clog2(MAX_COLORS);
   localparam int AB = $clog2(MAX_EDGES + 1);
   localparam int CNTB = $clog2(MAX_COLORS + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_OFF0  = 4'd1;
   localparam logic [3:0] S_OFF1  = 4'd2;
   localparam logic [3:0] S_OFF2  = 4'd3;
   localparam logic [3:0] S_SRCH  = 4'd4;
   localparam logic [3:0] S_SWAIT = 4'd5;
   localparam logic [3:0] S_TGT   = 4'd6;
   localparam logic [3:0] S_TWAIT = 4'd7;
   localparam logic [3:0] S_COL   = 4'd8;
   localparam logic [3:0] S_CWAIT = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0]            state_ff, state_in;
   logic [4:0]            cp_ff;
   logic [MAX_COLORS-1:0] visited_ff, visited_in;
   logic [NB-1:0]         node_ff, node_in;
   logic [31:0]           steps_ff, steps_in;
   logic [CNTB-1:0]       remain_ff, remain_in;
   logic [AB-1:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic [WEIGHT_BITS-1:0] frac_ff;
   logic                  found_ff, found_in;
   logic [CB-1:0]         fcolor_ff, fcolor_in;
   logic                  rv_ff, rv_in;

   // Memory ports.
   logic            off_we, edge_we, col_we;
   logic [OB-1:0]   off_wa, off_ra;
   logic [EB-1:0]   edge_wa, edge_ra;
   logic [NB-1:0]   col_wa, col_ra;
   logic [12:0]     off_rd;
   logic [9:0]      tgt_rd;
   logic [WEIGHT_BITS-1:0] wt_rd;
   logic [3:0]      col_rd;

   wrws_ram #(.WIDTH(13), .DEPTH(MAX_NODES + 1)) u_off (
      .clock(clock), .wr_en(off_we), .wr_addr(off_wa), .wr_data(req_entry_value),
      .rd_addr(off_ra), .rd_data(off_rd));
   wrws_ram #(.WIDTH(10), .DEPTH(MAX_EDGES)) u_tgt (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wa),
      .wr_data(req_entry_value[9:0]), .rd_addr(edge_ra), .rd_data(tgt_rd));
   wrws_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_EDGES)) u_wt (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wa),
      .wr_data(WEIGHT_BITS'(req_edge_weight)), .rd_addr(edge_ra), .rd_data(wt_rd));
   wrws_ram #(.WIDTH(4), .DEPTH(MAX_NODES)) u_col (
      .clock(clock), .wr_en(col_we), .wr_addr(col_wa),
      .wr_data(req_entry_value[3:0]), .rd_addr(col_ra), .rd_data(col_rd));

   logic accept;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Table writes go straight to the memories on acceptance.
   always_comb begin
      off_we  = accept && req_operation == OP_WRITE_OFFSET
                && 32'(req_table_index) < MAX_NODES + 1;
      edge_we = accept && req_operation == OP_WRITE_EDGE
                && 32'(req_table_index) < MAX_EDGES;
      col_we  = accept && req_operation == OP_WRITE_COLOR
                && 32'(req_table_index) < MAX_NODES;
      off_wa  = OB'(req_table_index);
      edge_wa = EB'(req_table_index);
      col_wa  = NB'(req_table_index);
   end

   logic [AB-1:0] off_clamp, mid;
   logic [CB-1:0] cidx;
   assign off_clamp = (32'(off_rd) > MAX_EDGES) ? AB'(MAX_EDGES) : AB'(off_rd);
   assign mid  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign cidx = CB'(col_rd);

   // Read address selection per state.
   always_comb begin
      off_ra  = (state_ff == S_OFF0) ? OB'(node_ff) : OB'(node_ff) + OB'(1);
      edge_ra = (state_ff == S_TGT) ? EB'(lo_ff) : EB'(mid);
      col_ra  = node_ff;
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      visited_in = visited_ff;
      node_in    = node_ff;
      steps_in   = steps_ff;
      remain_in  = remain_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      found_in   = found_ff;
      fcolor_in  = fcolor_ff;
      rv_in      = rv_ff;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               found_in  = 1'b0;
               fcolor_in = '0;
               state_in  = S_DONE;
               if (req_operation == OP_START) begin
                  node_in    = NB'(req_table_index);
                  visited_in = '0;
                  steps_in   = '0;
                  remain_in  = (32'(cp_ff) > MAX_COLORS) ? CNTB'(MAX_COLORS)
                                                        : CNTB'(cp_ff);
               end else if (req_operation == OP_STEP && remain_ff != '0) begin
                  state_in = S_OFF0;
                  if (steps_ff != 32'hFFFF_FFFF) begin
                     steps_in = steps_ff + 32'd1;
                  end
               end
            end
         end
         S_OFF0: state_in = S_OFF1;
         S_OFF1: begin
            lo_in    = off_clamp;
            state_in = S_OFF2;
         end
         S_OFF2: begin
            hi_in    = off_clamp - AB'(1);
            state_in = (lo_ff < off_clamp) ? S_SRCH : S_COL;
         end
         S_SRCH: state_in = (lo_ff < hi_ff) ? S_SWAIT : S_TGT;
         S_SWAIT: begin
            if (frac_ff <= wt_rd) begin
               hi_in = mid;
            end else begin
               lo_in = mid + AB'(1);
            end
            state_in = S_SRCH;
         end
         S_TGT: state_in = S_TWAIT;
         S_TWAIT: begin
            node_in  = NB'(tgt_rd);
            state_in = S_COL;
         end
         S_COL: state_in = S_CWAIT;
         S_CWAIT: begin
            if (!visited_ff[cidx]) begin
               visited_in[cidx] = 1'b1;
               if (remain_ff != '0) begin
                  remain_in = remain_ff - CNTB'(1);
               end
               found_in  = 1'b1;
               fcolor_in = cidx;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rv_ff || rsp_ready) begin
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cp_ff      <= 5'd1;
         visited_ff <= '0;
         node_ff    <= '0;
         steps_ff   <= '0;
         remain_ff  <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         visited_ff <= visited_in;
         node_ff    <= node_in;
         steps_ff   <= steps_in;
         remain_ff  <= remain_in;
         rv_ff      <= rv_in;
         if (csr_write_enable) begin
            cp_ff <= csr_write_data;
         end
      end
   end

   // Working registers and the response word, captured when handed over.
   logic [9:0]  rn_ff;
   logic [31:0] rs_ff;
   logic        rf_ff, rd_ff;
   logic [3:0]  rc_ff;
   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      found_ff  <= found_in;
      fcolor_ff <= fcolor_in;
      if (accept) begin
         frac_ff <= WEIGHT_BITS'(req_random_fraction);
      end
      if (state_ff == S_DONE && (!rv_ff || rsp_ready)) begin
         rn_ff <= 10'(node_ff);
         rs_ff <= steps_ff;
         rf_ff <= found_ff;
         rc_ff <= 4'(fcolor_ff);
         rd_ff <= (remain_ff == '0);
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_next_node   = rn_ff;
   assign rsp_step_count  = rs_ff;
   assign rsp_color_found = rf_ff;
   assign rsp_found_color = rc_ff;
   assign rsp_walk_done   = rd_ff;
endmodule
